[sv/assert_macros.svh]
// Assertion macros shared by the RTL files of the Content-Length completion unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is asserted
`define HCLC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent check that also holds during reset
`define HCLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/hclc_pkg.sv]
// Package for the Content-Length completion unit: widths, codes, label table, shared types.
package hclc_pkg;

  // Width of the byte and length counters
  localparam int unsigned CountWidth = 32;

  localparam logic [CountWidth-1:0] CntMax  = '1;
  localparam logic [CountWidth-1:0] CntQuot = CntMax / 10;
  localparam logic [3:0]            CntRem  = 4'(CntMax % 10);

  // CR LF "Content-Length:"
  localparam int unsigned LabelLen = 17;
  localparam logic [4:0]  LabelEnd = 5'(LabelLen);

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [2:0] {
    StNoTerminator = 3'd0,
    StNoLength     = 3'd1,
    StOverflow     = 3'd2,
    StEmptyValue   = 3'd3,
    StIncomplete   = 3'd4,
    StComplete     = 3'd5
  } status_e;

  // One input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_request;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic    worth_parsing;
    status_e status;
  } result_t;

  // Character expected at each position of the label
  function automatic logic [7:0] label_char(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd0:    ch = ChCr;
      5'd1:    ch = ChLf;
      5'd2:    ch = 8'h43; // C
      5'd3:    ch = 8'h6f; // o
      5'd4:    ch = 8'h6e; // n
      5'd5:    ch = 8'h74; // t
      5'd6:    ch = 8'h65; // e
      5'd7:    ch = 8'h6e; // n
      5'd8:    ch = 8'h74; // t
      5'd9:    ch = 8'h2d; // -
      5'd10:   ch = 8'h4c; // L
      5'd11:   ch = 8'h65; // e
      5'd12:   ch = 8'h6e; // n
      5'd13:   ch = 8'h67; // g
      5'd14:   ch = 8'h74; // t
      5'd15:   ch = 8'h68; // h
      5'd16:   ch = 8'h3a; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[sv/hclc_tracker.sv]
// Request framing state: terminator and label search, length accumulation, status.
`include "assert_macros.svh"

module hclc_tracker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  hclc_pkg::item_t item_i,
  output hclc_pkg::result_t result_o
);
  import hclc_pkg::*;

  // Value parsing phases
  localparam logic [1:0] PhSearch = 2'd0;
  localparam logic [1:0] PhSkipWs = 2'd1;
  localparam logic [1:0] PhDigits = 2'd2;
  localparam logic [1:0] PhDone   = 2'd3;

  logic [CountWidth-1:0] byte_count_q, byte_count_d;
  logic [1:0]            term_prog_q, term_prog_d;
  logic                  header_done_q, header_done_d;
  logic [CountWidth-1:0] header_len_q, header_len_d;
  logic [4:0]            label_prog_q, label_prog_d;
  logic [1:0]            phase_q, phase_d;
  logic [CountWidth-1:0] body_len_q, body_len_d;
  logic                  have_digit_q, have_digit_d;
  logic                  overflow_q, overflow_d;

  logic [7:0]            ch;
  logic [3:0]            digit;
  logic                  is_ws, is_digit;
  logic [1:0]            phase_ws;
  logic [7:0]            term_want;
  logic [CountWidth-1:0] goal;
  status_e               status;

  assign ch       = item_i.data_byte;
  assign digit    = ch[3:0];
  assign is_ws    = (ch == ChSpace) || (ch inside {[ChTab:ChCr]});
  assign is_digit = ch inside {[ChZero:ChNine]};

  // Next state for one byte
  always_comb begin
    byte_count_d  = byte_count_q;
    term_prog_d   = term_prog_q;
    header_done_d = header_done_q;
    header_len_d  = header_len_q;
    label_prog_d  = label_prog_q;
    phase_d       = phase_q;
    body_len_d    = body_len_q;
    have_digit_d  = have_digit_q;
    overflow_d    = overflow_q;
    phase_ws      = phase_q;
    term_want     = ChCr;

    if (item_i.new_request) begin
      byte_count_d  = '0;
      term_prog_d   = '0;
      header_done_d = 1'b0;
      header_len_d  = '0;
      label_prog_d  = '0;
      phase_d       = PhSearch;
      body_len_d    = '0;
      have_digit_d  = 1'b0;
      overflow_d    = 1'b0;
    end

    if (byte_count_d != CntMax) begin
      byte_count_d = byte_count_d + 1'b1;
    end

    if (!header_done_d) begin
      // whitespace skip, then digits
      phase_ws = phase_d;
      if (phase_d == PhSkipWs && !is_ws) begin
        phase_ws = PhDigits;
      end
      phase_d = phase_ws;
      if (phase_ws == PhDigits) begin
        if (is_digit) begin
          have_digit_d = 1'b1;
          if (body_len_d > CntQuot || (body_len_d == CntQuot && digit > CntRem)) begin
            overflow_d = 1'b1;
            phase_d    = PhDone;
          end else begin
            body_len_d = (body_len_d << 3) + (body_len_d << 1)
                         + CountWidth'(digit);
          end
        end else begin
          phase_d = PhDone;
        end
      end

      // label search
      if (phase_d == PhSearch) begin
        if (label_prog_d < LabelEnd && ch == label_char(label_prog_d)) begin
          label_prog_d = label_prog_d + 1'b1;
        end else begin
          label_prog_d = (ch == ChCr) ? 5'd1 : 5'd0;
        end
        if (label_prog_d >= LabelEnd) begin
          label_prog_d = LabelEnd;
          phase_d      = PhSkipWs;
        end
      end

      // CR LF CR LF search
      term_want = term_prog_d[0] ? ChLf : ChCr;
      if (ch == term_want) begin
        if (term_prog_d == 2'd3) begin
          header_done_d = 1'b1;
          header_len_d  = byte_count_d;
          term_prog_d   = 2'd0;
        end else begin
          term_prog_d = term_prog_d + 1'b1;
        end
      end else begin
        term_prog_d = (ch == ChCr) ? 2'd1 : 2'd0;
      end
    end
  end

  // Status from the state after this byte
  always_comb begin
    goal = header_len_d + body_len_d;
    if (!header_done_d) begin
      status = StNoTerminator;
    end else if (phase_d == PhSearch) begin
      status = StNoLength;
    end else if (overflow_d) begin
      status = StOverflow;
    end else if (!have_digit_d) begin
      status = StEmptyValue;
    end else if (body_len_d > (CntMax - header_len_d)) begin
      status = StIncomplete;
    end else if (byte_count_d >= goal) begin
      status = StComplete;
    end else begin
      status = StIncomplete;
    end
  end

  assign result_o.status        = status;
  assign result_o.worth_parsing = (status != StIncomplete);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      term_prog_q   <= '0;
      header_done_q <= 1'b0;
      header_len_q  <= '0;
      label_prog_q  <= '0;
      phase_q       <= PhSearch;
      body_len_q    <= '0;
      have_digit_q  <= 1'b0;
      overflow_q    <= 1'b0;
    end else if (step_i) begin
      byte_count_q  <= byte_count_d;
      term_prog_q   <= term_prog_d;
      header_done_q <= header_done_d;
      header_len_q  <= header_len_d;
      label_prog_q  <= label_prog_d;
      phase_q       <= phase_d;
      body_len_q    <= body_len_d;
      have_digit_q  <= have_digit_d;
      overflow_q    <= overflow_d;
    end
  end

  `HCLC_ASSERT(a_header_sticky, clk_i, rst_ni, header_done_q && !(step_i && item_i.new_request) |=> header_done_q, "header_done cleared without a new request")
  `HCLC_ASSERT(a_count_monotonic, clk_i, rst_ni, !(step_i && item_i.new_request) |=> byte_count_q >= $past(byte_count_q), "byte count went backwards")
  `HCLC_ASSERT(a_label_full, clk_i, rst_ni, phase_q != PhSearch |-> label_prog_q == LabelEnd, "value parsing without complete label")
  `HCLC_ASSERT(a_overflow_done, clk_i, rst_ni, overflow_q |-> phase_q == PhDone, "overflow flagged while value still open")

endmodule

[sv/http_content_length_completion_unit.sv]
// Top level of the HTTP Content-Length completion unit: input register, tracker, result register.
// Takes one request byte per transaction and returns one status per byte, telling whether the
// bytes so far are worth handing to a full parser. Throughput is one byte per clock cycle while
// the receiver does not stall; a byte passes from input acceptance through the input register,
// then the result register. The rate is set by the per-byte framing state loop in hclc_tracker,
// whose next state is combinational: label and terminator match, one decimal multiply-accumulate
// by shift-add, and the length add and compare for the completion check. Assert new_request_i
// with the first byte of each request to clear the framing state.
`include "assert_macros.svh"

module http_content_length_completion_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       new_request_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       worth_parsing_o,
  output logic [2:0] status_o
);
  import hclc_pkg::*;

  logic    s1_valid_q, s1_valid_d;
  item_t   s1_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  result_t trk_res;
  logic    out_ready, s1_adv, in_accept;

  // Handshake: the input register advances whenever the result register is free or draining
  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_adv    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q.data_byte   <= data_byte_i;
      s1_item_q.new_request <= new_request_i;
    end
    if (s1_adv) begin
      out_res_q <= trk_res;
    end
  end

  hclc_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .item_i   (s1_item_q),
    .result_o (trk_res)
  );

  assign out_valid_o     = out_valid_q;
  assign worth_parsing_o = out_res_q.worth_parsing;
  assign status_o        = out_res_q.status;

  `HCLC_ASSERT(a_adv_fills_out, clk_i, rst_ni, s1_adv |=> out_valid_o, "advanced transaction did not reach the result register")
  `HCLC_ASSERT(a_worth_status, clk_i, rst_ni, out_valid_o && !worth_parsing_o |-> status_o == StIncomplete, "not worth parsing without incomplete status")
  `HCLC_ASSERT(a_no_drop, clk_i, rst_ni, s1_valid_q && !s1_adv |=> s1_valid_q, "held transaction lost in the input register")
  `HCLC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o && !s1_valid_q, "pipeline not empty during reset")

endmodule

[sim/http_content_length_completion_unit_tb.sv]
// Testbench for the HTTP Content-Length completion unit: byte stimulus, status prediction, checks.
`timescale 1ns / 100ps

module http_content_length_completion_unit_tb;
  import hclc_pkg::*;

  localparam int unsigned LongHold   = 64;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned TimeoutNs  = 4_000_000;

  // CR LF "Content-Length:", first character in the top byte
  localparam logic [8*LabelLen-1:0] LabelPat = {ChCr, ChLf, "Content-Length:"};

  typedef enum logic [1:0] {
    PhLabel,
    PhBlank,
    PhDigits,
    PhDone
  } parse_phase_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       new_request_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       worth_parsing_o;
  logic [2:0] status_o;

  // Framing state mirrored from the block
  logic [CountWidth-1:0] rx_count;
  logic [CountWidth-1:0] hdr_len;
  logic [CountWidth-1:0] body_len;
  logic [1:0]            crlf_seen;
  logic                  hdr_done;
  logic [4:0]            label_seen;
  parse_phase_e          phase;
  logic                  got_digit;
  logic                  len_ovf;

  result_t     pending_status[$];
  logic [7:0]  request_bytes[$];
  int unsigned fail_count;
  int unsigned items_sent;
  bit          idle_on;
  bit          hold_req;

  http_content_length_completion_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .new_request_i   (new_request_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .worth_parsing_o (worth_parsing_o),
    .status_o        (status_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void clear_framing();
    rx_count   = '0;
    hdr_len    = '0;
    body_len   = '0;
    crlf_seen  = 2'd0;
    hdr_done   = 1'b0;
    label_seen = 5'd0;
    phase      = PhLabel;
    got_digit  = 1'b0;
    len_ovf    = 1'b0;
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == ChSpace || (ch >= ChTab && ch <= ChCr);
  endfunction

  // Advances the framing state by one byte and returns the status after it
  function automatic status_e framing_status(input logic [7:0] ch, input logic first);
    logic [3:0]          digit;
    logic [7:0]          want;
    logic [CountWidth:0] goal;
    if (first) clear_framing();
    if (rx_count != CntMax) rx_count = rx_count + 1'b1;
    if (!hdr_done) begin
      // value parsing uses the phase held before this byte
      if (phase == PhBlank && !is_blank(ch)) phase = PhDigits;
      if (phase == PhDigits) begin
        if (ch >= ChZero && ch <= ChNine) begin
          digit = 4'(ch - ChZero);
          got_digit = 1'b1;
          if (body_len > CntQuot || (body_len == CntQuot && digit > CntRem)) begin
            len_ovf = 1'b1;
            phase = PhDone;
          end else begin
            body_len = body_len * 10 + CountWidth'(digit);
          end
        end else begin
          phase = PhDone;
        end
      end
      // label search
      if (phase == PhLabel) begin
        if (label_seen < LabelEnd && ch == LabelPat[8*(LabelLen-1-label_seen) +: 8])
          label_seen = label_seen + 5'd1;
        else
          label_seen = (ch == ChCr) ? 5'd1 : 5'd0;
        if (label_seen >= LabelEnd) begin
          label_seen = LabelEnd;
          phase = PhBlank;
        end
      end
      // CR LF CR LF search
      want = crlf_seen[0] ? ChLf : ChCr;
      if (ch == want) begin
        if (crlf_seen == 2'd3) begin
          hdr_done = 1'b1;
          hdr_len = rx_count;
          crlf_seen = 2'd0;
        end else begin
          crlf_seen = crlf_seen + 2'd1;
        end
      end else begin
        crlf_seen = (ch == ChCr) ? 2'd1 : 2'd0;
      end
    end
    goal = {1'b0, hdr_len} + {1'b0, body_len};
    if (!hdr_done) return StNoTerminator;
    if (phase == PhLabel) return StNoLength;
    if (len_ovf) return StOverflow;
    if (!got_digit) return StEmptyValue;
    if (goal > {1'b0, CntMax}) return StIncomplete;
    if ({1'b0, rx_count} >= goal) return StComplete;
    return StIncomplete;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // Offers one byte, optionally after an idle burst, and records its expected status
  task automatic send_byte(input logic [7:0] ch, input logic first);
    result_t exp_r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= ch;
    new_request_i <= first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    exp_r.status        = framing_status(ch, first);
    exp_r.worth_parsing = (exp_r.status != StIncomplete);
    pending_status.push_back(exp_r);
    items_sent++;
  endtask

  // Sender goes quiet until every outstanding status has returned
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
  endtask

  task automatic add_random_bytes(input int unsigned n);
    repeat (n) request_bytes.push_back(8'($urandom));
  endtask

  task automatic send_request();
    for (int i = 0; i < request_bytes.size(); i++) send_byte(request_bytes[i], i == 0);
    request_bytes.delete();
  endtask

  // Builds one request: mostly well formed with random content, some broken, some noise
  task automatic build_request();
    int unsigned     pick;
    longint unsigned val;
    bit              small_val;
    logic [7:0]      blanks[6];
    blanks = '{ChSpace, ChTab, 8'h0b, 8'h0c, ChCr, ChLf};
    small_val = 1'b0;
    val = 0;
    request_bytes.delete();
    if ($urandom_range(0, 7) == 0) begin
      add_random_bytes($urandom_range(4, 30));
      return;
    end
    if ($urandom_range(0, 3) == 0) add_text("GET / HTTP/1.1");
    else add_random_bytes($urandom_range(0, 6));
    // label line
    pick = $urandom_range(0, 9);
    if (pick == 0) add_text("\r\nHost: a");
    else if (pick == 1) add_text("\r\ncontent-length:");
    else if (pick == 2) add_text("\r\nContent-Len\r\n");
    else add_text("\r\nContent-Length:");
    repeat ($urandom_range(0, 3)) request_bytes.push_back(blanks[$urandom_range(0, 5)]);
    // value
    pick = $urandom_range(0, 11);
    if (pick == 1) begin
      val = longint'(CntMax);
    end else if (pick == 2) begin
      val = longint'(CntMax) + 1;
    end else if (pick == 3) begin
      add_text("9");
      repeat ($urandom_range(10, 13)) request_bytes.push_back(ChZero + 8'($urandom_range(0, 9)));
    end else if (pick == 4) begin
      val = longint'(CntMax) - $urandom_range(0, 200);
    end else if (pick != 0) begin
      val = $urandom_range(0, 16);
      small_val = 1'b1;
      if ($urandom_range(0, 3) == 0) add_text("0");
    end
    if (pick == 1 || pick == 2 || pick == 4 || small_val) add_text($sformatf("%0d", val));
    // end of header
    pick = $urandom_range(0, 9);
    if (pick == 0) add_text("\r\n\r");
    else if (pick <= 3) add_text("\r\nHost: x\r\n\r\n");
    else if (pick == 4) add_text(" ;\r\n\r\n");
    else add_text("\r\n\r\n");
    // body
    if (small_val) add_random_bytes($urandom_range(0, int'(val) + 3));
    else add_random_bytes($urandom_range(0, 6));
  endtask

  task automatic send_random_request();
    int unsigned n;
    build_request();
    n = request_bytes.size();
    for (int i = 0; i < n; i++)
      send_byte(request_bytes[i], i == 0 || $urandom_range(0, 63) == 0);
    request_bytes.delete();
  endtask

  // Byte value extremes, clear in mid-stream, terminator without a length field
  task automatic test_byte_extremes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    request_bytes.delete();
    add_text("\r\n\r\n");
    for (int i = 0; i < request_bytes.size(); i++) send_byte(request_bytes[i], 1'b0);
    request_bytes.delete();
    send_byte(8'h00, 1'b0);
  endtask

  // Whitespace before the value, body arriving to completion
  task automatic test_complete_request();
    add_text("\r\nContent-Length: \t2\r\n\r\nok");
    send_request();
    send_byte(8'h21, 1'b0);
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    hold_req = 1'b1;
    add_text("\r\nContent-Length:3\r\n\r\nabc");
    send_request();
    wait_drained();
  endtask

  task automatic test_random_requests(input int unsigned n_items, input bit allow_idle);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      send_random_request();
    end
  endtask

  // Result checking
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        note_failure($sformatf("unexpected result transaction, worth %0d code %0d",
                               worth_parsing_o, status_o));
      end else begin
        exp_r = pending_status.pop_front();
        if (status_o !== exp_r.status)
          note_failure($sformatf("status code mismatch: exp %0d got %0d",
                                 exp_r.status, status_o));
        if (worth_parsing_o !== exp_r.worth_parsing)
          note_failure($sformatf("worth_parsing mismatch: exp %0d got %0d",
                                 exp_r.worth_parsing, worth_parsing_o));
      end
    end
  end

  // Receiver stalls: random bursts, plus one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("status: fail");
    $finish;
  end

  initial begin
    fail_count = 0;
    items_sent = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    clear_framing();
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    data_byte_i   <= 8'h00;
    new_request_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_byte_extremes();
    test_complete_request();
    test_backpressure();
    test_random_requests(680, 1'b1);
    idle_on = 1'b0;
    test_random_requests(100, 1'b0);

    // wind down and let the pipeline empty
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_status.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_status.size()));
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[http_content_length_completion_unit.f]
+incdir+sv
sv/hclc_pkg.sv
sv/hclc_tracker.sv
sv/http_content_length_completion_unit.sv
sim/http_content_length_completion_unit_tb.sv
